### rtl/core/rrva_pkg.sv
package rrva_pkg;

  localparam int NUM_VCS_DEF = 8;
  localparam int CH_W        = 3;
  localparam int ACT_W       = 4;
  localparam int CNT_W       = 4;
  localparam int ACTIVE_RST  = 8;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_PICK    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [CH_W-1:0] channel;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]  winner;
    logic             winner_valid;
    logic             channel_requested;
    logic [CNT_W-1:0] request_count;
    logic             bad_channel;
  } res_t;

  // input register contents handed to the arbitration stage
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } stage_t;

endpackage

### rtl/core/rrva_stream_if.sv
interface rrva_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/round_robin_vc_arbiter_unit.sv
// Round-robin virtual-channel arbiter. One command word is taken per cycle
// while res is not stalled, and each gives one result word: the command lands
// in an input register, then request/pick/release is applied to the pending
// bits in a single pass through a rotating priority encoder over NUM_VCS bits
// and registered into the result stage. Both stages move together, so back
// pressure on res stalls cmd only when the result register is still full.
// A pick keeps returning the held winner until a release or a request to an
// active channel drops the hold. Writing cfg_data (active channel count, 0
// read as 1, saturated at NUM_VCS) clears all pending requests and the hold;
// the last winner is kept. Write it only while no command is in flight.
module round_robin_vc_arbiter_unit
  import rrva_pkg::*;
#(
  parameter int NUM_VCS = NUM_VCS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [ACT_W-1:0] cfg_data,
  rrva_stream_if.sink      cmd,
  rrva_stream_if.source    res
);

  stage_t stage;
  logic   advance;

  rrva_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_data  (cmd.data),
    .in_ready (cmd.ready),
    .advance  (advance),
    .stage    (stage)
  );

  rrva_core #(
    .NUM_VCS (NUM_VCS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .advance   (advance),
    .res_valid (res.valid),
    .res_data  (res.data),
    .res_ready (res.ready)
  );

endmodule

### rtl/core/rrva_in_stage.sv
module rrva_in_stage
  import rrva_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  cmd_t   in_data,
  output logic   in_ready,
  input  logic   advance,
  output stage_t stage
);

  logic valid;
  cmd_t data;

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

  assign stage.valid = valid;
  assign stage.cmd   = data;

endmodule

### rtl/core/rrva_pick.sv
module rrva_pick
  import rrva_pkg::*;
#(
  parameter int NUM_VCS = NUM_VCS_DEF,
  parameter int LG_W    = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1
) (
  input  logic [NUM_VCS-1:0] pending,
  input  logic [ACT_W-1:0]   active,
  input  logic [LG_W-1:0]    last_grant,
  output logic               found,
  output logic [LG_W-1:0]    idx
);

  logic [NUM_VCS-1:0] live;
  logic [NUM_VCS-1:0] upper;
  logic [LG_W-1:0]    idx_upper;
  logic [LG_W-1:0]    idx_any;

  always_comb begin
    for (int i = 0; i < NUM_VCS; i++) begin
      live[i]  = pending[i] && (i < int'(active));
      upper[i] = live[i] && (i > int'(last_grant));
    end
  end

  // lowest set bit wins; channels after the last winner come first
  always_comb begin
    idx_upper = '0;
    idx_any   = '0;
    for (int i = NUM_VCS - 1; i >= 0; i--) begin
      if (upper[i]) idx_upper = LG_W'(i);
      if (live[i])  idx_any   = LG_W'(i);
    end
  end

  assign found = |live;
  assign idx   = (|upper) ? idx_upper : idx_any;

endmodule

### rtl/core/rrva_core.sv
module rrva_core
  import rrva_pkg::*;
#(
  parameter int NUM_VCS = NUM_VCS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [ACT_W-1:0] cfg_data,
  input  stage_t           stage,
  output logic             advance,
  output logic             res_valid,
  output res_t             res_data,
  input  logic             res_ready
);

  localparam int LG_W = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
  localparam int ACT_RST_CLAMP = (ACTIVE_RST > NUM_VCS) ? NUM_VCS : ACTIVE_RST;

  logic [NUM_VCS-1:0] pending;
  logic [NUM_VCS-1:0] pending_next;
  logic [LG_W-1:0]    last_grant;
  logic [LG_W-1:0]    last_grant_next;
  logic               hold;
  logic               hold_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [ACT_W-1:0]   active;
  logic [ACT_W-1:0]   active_cfg;

  logic               bad;
  logic               ch_set;
  logic               ch_set_next;
  logic               pick_found;
  logic [LG_W-1:0]    pick_idx;
  action_t            action;
  res_t               result;

  rrva_pick #(
    .NUM_VCS (NUM_VCS),
    .LG_W    (LG_W)
  ) u_pick (
    .pending    (pending),
    .active     (active),
    .last_grant (last_grant),
    .found      (pick_found),
    .idx        (pick_idx)
  );

  // register value 0 acts as 1, anything above the channel count saturates
  always_comb begin
    if (cfg_data == '0) begin
      active_cfg = ACT_W'(1);
    end else if (int'(cfg_data) > NUM_VCS) begin
      active_cfg = ACT_W'(NUM_VCS);
    end else begin
      active_cfg = cfg_data;
    end
  end

  assign action  = action_t'(stage.cmd.action);
  assign bad     = {1'b0, stage.cmd.channel} >= active;
  assign advance = stage.valid && (!res_valid || res_ready);

  always_comb begin
    ch_set = 1'b0;
    for (int i = 0; i < NUM_VCS; i++) begin
      if (int'(stage.cmd.channel) == i) ch_set = pending[i];
    end
  end

  always_comb begin
    pending_next    = pending;
    last_grant_next = last_grant;
    hold_next       = hold;
    count_next      = count;
    unique case (action)
      ACT_REQUEST: begin
        if (!bad) begin
          for (int i = 0; i < NUM_VCS; i++) begin
            if (int'(stage.cmd.channel) == i) pending_next[i] = 1'b1;
          end
          hold_next = 1'b0;
          if (!ch_set) count_next = count + CNT_W'(1);
        end
      end
      ACT_PICK: begin
        if (!hold && pick_found) begin
          last_grant_next = pick_idx;
          hold_next       = 1'b1;
        end
      end
      ACT_RELEASE: begin
        pending_next[last_grant] = 1'b0;
        hold_next                = 1'b0;
        // the count only covers active channels
        if (pending[last_grant] && (int'(last_grant) < int'(active))) begin
          count_next = count - CNT_W'(1);
        end
      end
      ACT_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ch_set_next = 1'b0;
    for (int i = 0; i < NUM_VCS; i++) begin
      if (int'(stage.cmd.channel) == i) ch_set_next = pending_next[i];
    end
  end

  always_comb begin
    result.winner            = hold_next ? CH_W'(last_grant_next) : '0;
    result.winner_valid      = hold_next;
    result.channel_requested = !bad && ch_set_next;
    result.request_count     = count_next;
    result.bad_channel       = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_grant <= '0;
      hold       <= 1'b0;
      count      <= '0;
      active     <= ACT_W'(ACT_RST_CLAMP);
    end else if (cfg_we) begin
      active  <= active_cfg;
      pending <= '0;
      hold    <= 1'b0;
      count   <= '0;
    end else if (advance) begin
      pending    <= pending_next;
      last_grant <= last_grant_next;
      hold       <= hold_next;
      count      <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= result;
    end
  end

endmodule

### rtl/core/rrva_checker.sv
module rrva_checker
  import rrva_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result word changed while stalled");

  a_winner_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.winner_valid |-> res_data.winner == '0)
    else $error("winner nonzero without a grant");

  a_bad_no_req: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.bad_channel |-> !res_data.channel_requested)
    else $error("bad channel reported as requested");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind round_robin_vc_arbiter_unit rrva_checker u_rrva_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
